// ===== rtl/acs_pkg.sv =====
package acs_pkg;

    // Sequencer constants
    localparam int INIT_DELAY     = 16;
    localparam int MAX_ACCUM_LOG2 = 6;

    // Register map
    localparam int ADDR_W     = 5;

    typedef enum logic [2:0] {
        REG_PRESCALE      = 3'd0,
        REG_SAMPLE_DELAY  = 3'd1,
        REG_SAMPLE_LENGTH = 3'd2,
        REG_ACCUM_LOG2    = 3'd3,
        REG_EIGHT_BIT     = 3'd4,
        REG_WINDOW_MODE   = 3'd5,
        REG_WINDOW_LOW    = 3'd6,
        REG_WINDOW_HIGH   = 3'd7
    } t_reg;

    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_ENABLE  = 3'd1,
        OP_DISABLE = 3'd2,
        OP_START   = 3'd3,
        OP_CLEAR   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        PH_DISABLED   = 3'd0,
        PH_IDLE       = 3'd1,
        PH_STARTING   = 3'd2,
        PH_WAITING    = 3'd3,
        PH_CONVERTING = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        WIN_NONE    = 3'd0,
        WIN_BELOW   = 3'd1,
        WIN_ABOVE   = 3'd2,
        WIN_INSIDE  = 3'd3,
        WIN_OUTSIDE = 3'd4
    } t_win_mode;

    typedef struct packed {
        logic [8:0]  prescale_factor;
        logic [3:0]  sample_delay;
        logic [4:0]  sample_length;
        logic [2:0]  accum_log2;
        logic        eight_bit;
        logic [2:0]  window_mode;
        logic [15:0] window_low;
        logic [15:0] window_high;
    } t_cfg;

    typedef struct packed {
        logic        busy_res;
        logic [15:0] result;
        logic        result_ready;
        logic        window_hit;
        logic        sample_now;
    } t_result;

endpackage

// ===== rtl/acs_if.sv =====
interface acs_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic       clear_ready;
    logic       clear_window;
    logic [9:0] sample_code;

    modport source (output valid, operation, clear_ready, clear_window, sample_code,
                    input ready);
    modport sink   (input valid, operation, clear_ready, clear_window, sample_code,
                    output ready);
endinterface

interface acs_out_if;
    logic        valid;
    logic        ready;
    logic        busy_res;
    logic [15:0] result;
    logic        result_ready;
    logic        window_hit;
    logic        sample_now;

    modport source (output valid, busy_res, result, result_ready, window_hit, sample_now,
                    input ready);
    modport sink   (input valid, busy_res, result, result_ready, window_hit, sample_now,
                    output ready);
endinterface

// ===== rtl/acs_cfg_regs.sv =====
module acs_cfg_regs
    import acs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic wr_en;
    t_reg idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg'(paddr[ADDR_W-1:2]);

    // Write the addressed register on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prescale_factor <= 9'd2;
            r_cfg.sample_delay    <= '0;
            r_cfg.sample_length   <= '0;
            r_cfg.accum_log2      <= '0;
            r_cfg.eight_bit       <= 1'b0;
            r_cfg.window_mode     <= '0;
            r_cfg.window_low      <= '0;
            r_cfg.window_high     <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_PRESCALE:      r_cfg.prescale_factor <= pwdata[8:0];
                REG_SAMPLE_DELAY:  r_cfg.sample_delay    <= pwdata[3:0];
                REG_SAMPLE_LENGTH: r_cfg.sample_length   <= pwdata[4:0];
                REG_ACCUM_LOG2:    r_cfg.accum_log2      <= pwdata[2:0];
                REG_EIGHT_BIT:     r_cfg.eight_bit       <= pwdata[0];
                REG_WINDOW_MODE:   r_cfg.window_mode     <= pwdata[2:0];
                REG_WINDOW_LOW:    r_cfg.window_low      <= pwdata[15:0];
                REG_WINDOW_HIGH:   r_cfg.window_high     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (idx)
            REG_PRESCALE:      prdata = {23'd0, r_cfg.prescale_factor};
            REG_SAMPLE_DELAY:  prdata = {28'd0, r_cfg.sample_delay};
            REG_SAMPLE_LENGTH: prdata = {27'd0, r_cfg.sample_length};
            REG_ACCUM_LOG2:    prdata = {29'd0, r_cfg.accum_log2};
            REG_EIGHT_BIT:     prdata = {31'd0, r_cfg.eight_bit};
            REG_WINDOW_MODE:   prdata = {29'd0, r_cfg.window_mode};
            REG_WINDOW_LOW:    prdata = {16'd0, r_cfg.window_low};
            REG_WINDOW_HIGH:   prdata = {16'd0, r_cfg.window_high};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/acs_core.sv =====
module acs_core
    import acs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_accept,
    input  logic [2:0] i_operation,
    input  logic       i_clear_ready,
    input  logic       i_clear_window,
    input  logic [9:0] i_sample_code,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [8:0]  r_presc, n_presc;
    logic [8:0]  r_adc, n_adc;
    logic [6:0]  r_scnt, n_scnt;
    logic [15:0] r_accum, n_accum;
    logic        r_first, n_first;
    logic        r_ready, n_ready;
    logic        r_win, n_win;

    logic [8:0]  eff_presc;
    logic [2:0]  eff_accum;
    logic [6:0]  accum_lim;
    logic [8:0]  adc_dec;
    logic [8:0]  presc_inc;
    logic [6:0]  scnt_inc;
    logic [9:0]  sample_val;
    logic [8:0]  wait_len;
    logic        win_hit;
    logic        sampled;

    // Clamp configuration to its working range
    always_comb begin
        if (i_cfg.prescale_factor < 9'd2) begin
            eff_presc = 9'd2;
        end else if (i_cfg.prescale_factor > 9'd256) begin
            eff_presc = 9'd256;
        end else begin
            eff_presc = i_cfg.prescale_factor;
        end
        if (i_cfg.accum_log2 > 3'(MAX_ACCUM_LOG2)) begin
            eff_accum = 3'(MAX_ACCUM_LOG2);
        end else begin
            eff_accum = i_cfg.accum_log2;
        end
    end

    assign accum_lim  = 7'd1 << eff_accum;
    assign adc_dec    = (r_adc != 9'd0) ? r_adc - 9'd1 : 9'd0;
    assign presc_inc  = r_presc + 9'd1;
    assign scnt_inc   = r_scnt + 7'd1;
    assign sample_val = i_cfg.eight_bit ? {2'b00, i_sample_code[9:2]} : i_sample_code;
    assign wait_len   = 9'd2 + {5'd0, i_cfg.sample_delay};

    // Window compare on the finished sum
    always_comb begin
        case (t_win_mode'(i_cfg.window_mode))
            WIN_BELOW:   win_hit = r_accum < i_cfg.window_low;
            WIN_ABOVE:   win_hit = r_accum > i_cfg.window_high;
            WIN_INSIDE:  win_hit = (r_accum > i_cfg.window_low) &&
                                   (r_accum < i_cfg.window_high);
            WIN_OUTSIDE: win_hit = (r_accum < i_cfg.window_low) ||
                                   (r_accum > i_cfg.window_high);
            default:     win_hit = 1'b0;
        endcase
    end

    // Next state for one beat
    always_comb begin
        n_phase = r_phase;
        n_presc = r_presc;
        n_adc   = r_adc;
        n_scnt  = r_scnt;
        n_accum = r_accum;
        n_first = r_first;
        n_ready = r_ready;
        n_win   = r_win;
        sampled = 1'b0;
        if (i_accept) begin
            case (t_op'(i_operation))
                OP_TICK: begin
                    if (r_phase == PH_STARTING) begin
                        if (adc_dec == 9'd0) begin
                            n_adc   = r_first ? wait_len + 9'(INIT_DELAY) : wait_len;
                            n_first = 1'b0;
                            n_presc = 9'd0;
                            n_phase = PH_WAITING;
                        end else begin
                            n_adc = adc_dec;
                        end
                    end else if (r_phase == PH_WAITING || r_phase == PH_CONVERTING) begin
                        if (presc_inc < eff_presc) begin
                            n_presc = presc_inc;
                        end else begin
                            n_presc = 9'd0;
                            n_adc   = adc_dec;
                            if (adc_dec == 9'd0) begin
                                if (r_phase == PH_WAITING) begin
                                    n_accum = (r_scnt == 7'd0) ? {6'd0, sample_val}
                                                               : r_accum + {6'd0, sample_val};
                                    n_adc   = 9'd11 + {4'd0, i_cfg.sample_length};
                                    n_phase = PH_CONVERTING;
                                    sampled = 1'b1;
                                end else begin
                                    n_scnt = scnt_inc;
                                    if (scnt_inc < accum_lim) begin
                                        n_adc   = wait_len;
                                        n_phase = PH_WAITING;
                                    end else begin
                                        n_phase = PH_IDLE;
                                        n_ready = 1'b1;
                                        if (win_hit) begin
                                            n_win = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                    end
                end
                OP_ENABLE: begin
                    n_first = 1'b1;
                    if (r_phase == PH_DISABLED) begin
                        n_phase = PH_IDLE;
                    end
                end
                OP_DISABLE: begin
                    n_first = 1'b1;
                    n_phase = PH_DISABLED;
                    n_presc = 9'd0;
                    n_adc   = 9'd0;
                    n_scnt  = 7'd0;
                end
                OP_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_phase = PH_STARTING;
                        n_scnt  = 7'd0;
                        n_presc = 9'd0;
                        n_adc   = {1'b0, eff_presc[8:1]} + 9'd2;
                    end
                end
                OP_CLEAR: begin
                    if (i_clear_ready) begin
                        n_ready = 1'b0;
                    end
                    if (i_clear_window) begin
                        n_win = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Hold sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DISABLED;
            r_presc <= '0;
            r_adc   <= '0;
            r_scnt  <= '0;
            r_accum <= '0;
            r_first <= 1'b0;
            r_ready <= 1'b0;
            r_win   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_presc <= n_presc;
            r_adc   <= n_adc;
            r_scnt  <= n_scnt;
            r_accum <= n_accum;
            r_first <= n_first;
            r_ready <= n_ready;
            r_win   <= n_win;
        end
    end

    // Result beat reflects the state after the update
    assign o_res.busy_res     = (n_phase != PH_DISABLED) && (n_phase != PH_IDLE);
    assign o_res.result       = n_accum;
    assign o_res.result_ready = n_ready;
    assign o_res.window_hit   = n_win;
    assign o_res.sample_now   = sampled;

    a_sample_enters_convert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && sampled) |=> (r_phase == PH_CONVERTING))
        else $error("sample latched without entering conversion");

    a_disable_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && t_op'(i_operation) == OP_DISABLE) |=>
        (r_phase == PH_DISABLED && r_scnt == 7'd0 && r_adc == 9'd0 && r_first))
        else $error("disable did not clear the sequencer");

    a_idle_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_accept |=> ($stable(r_phase) && $stable(r_accum) && $stable(r_ready)))
        else $error("state moved without an accepted beat");

endmodule

// ===== rtl/acs_out_buf.sv =====
module acs_out_buf
    import acs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_pop_ready,
    output t_result o_data
);

    logic [1:0] r_count;
    t_result    r_ent0;
    t_result    r_ent1;
    logic       pop;

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_ent0;
    assign pop     = o_valid && i_pop_ready;

    // Advance the two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({i_push, pop})
            2'b10: begin
                if (r_count == 2'd0) begin
                    r_ent0 <= i_data;
                end else begin
                    r_ent1 <= i_data;
                end
            end
            2'b01: begin
                r_ent0 <= r_ent1;
            end
            2'b11: begin
                if (r_count == 2'd1) begin
                    r_ent0 <= i_data;
                end else begin
                    r_ent0 <= r_ent1;
                    r_ent1 <= i_data;
                end
            end
            default: ;
        endcase
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != 2'd2))
        else $error("push into a full result queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result queue count out of range");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_pop_ready) |=> $stable(r_ent0))
        else $error("waiting result beat changed");

endmodule

// ===== rtl/adc_conversion_sequencer.sv =====
// Converter sequencer: each input beat is one CPU-clock tick or one event (enable, disable,
// start, clear flags) and yields exactly one status beat taken after the update, with busy,
// the running sum, both interrupt flags and the sampling strobe. One beat is accepted every
// clock cycle; the state update is a single combinational pass into the state registers, and
// a two-entry result queue lets input continue while up to two result beats wait downstream,
// so input stalls only when that queue is full. Registers are to be written over the APB port
// only while no conversion is running; the block itself does not enforce this. pready is always high.
module adc_conversion_sequencer
    import acs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    acs_in_if.sink            i_in,
    acs_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    t_cfg    cfg;
    t_result core_res;
    t_result head;
    logic    buf_ready;
    logic    accept;

    assign i_in.ready = buf_ready;
    assign accept     = i_in.valid && buf_ready;

    acs_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    acs_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_accept       (accept),
        .i_operation    (i_in.operation),
        .i_clear_ready  (i_in.clear_ready),
        .i_clear_window (i_in.clear_window),
        .i_sample_code  (i_in.sample_code),
        .o_res          (core_res)
    );

    acs_out_buf u_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_data      (core_res),
        .o_ready     (buf_ready),
        .o_valid     (o_out.valid),
        .i_pop_ready (o_out.ready),
        .o_data      (head)
    );

    // Drive the result channel from the queue head
    assign o_out.busy_res     = head.busy_res;
    assign o_out.result       = head.result;
    assign o_out.result_ready = head.result_ready;
    assign o_out.window_hit   = head.window_hit;
    assign o_out.sample_now   = head.sample_now;

endmodule

// ===== tb/sv/adc_conversion_sequencer_tb.sv =====
`timescale 1ns / 100ps

module adc_conversion_sequencer_tb;
    import acs_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 500;

    typedef struct {
        logic [2:0] operation;
        logic       clear_ready;
        logic       clear_window;
        logic [9:0] sample_code;
    } t_seq_cmd;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    acs_in_if  in_bus ();
    acs_out_if out_bus ();

    adc_conversion_sequencer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Commands waiting to be driven and status beats waiting to be seen
    t_seq_cmd cmd_queue[$];
    t_result  expected_status[$];
    int       items_queued;
    int       error_count;
    int       quiet_cycles;

    // Driver and monitor pacing
    int       send_gap;
    int       send_calm;
    int       recv_hold;
    int       recv_calm;
    t_seq_cmd next_cmd;
    t_seq_cmd sent_cmd;
    t_result  want;

    // Mirror of the register file and of the sequencer state
    t_cfg        model_cfg;
    t_phase      seq_phase;
    logic [8:0]  seq_pre_cnt;
    logic [8:0]  seq_clk_cnt;
    logic [6:0]  seq_samples;
    logic [15:0] seq_sum;
    logic        seq_first;
    logic        seq_ready;
    logic        seq_window;

    function automatic int prescale_ticks();
        if (model_cfg.prescale_factor < 2) return 2;
        if (model_cfg.prescale_factor > 256) return 256;
        return int'(model_cfg.prescale_factor);
    endfunction

    function automatic int samples_per_result();
        if (model_cfg.accum_log2 > MAX_ACCUM_LOG2) return 1 << MAX_ACCUM_LOG2;
        return 1 << model_cfg.accum_log2;
    endfunction

    // Advance the sequencer mirror by one command and return the status beat
    function automatic t_result predict_status(t_seq_cmd cmd);
        t_result    st;
        logic       sampled;
        logic       hit;
        logic [9:0] code;
        int         p;
        p       = prescale_ticks();
        sampled = 1'b0;
        case (cmd.operation)
            OP_TICK: begin
                if (seq_phase == PH_STARTING) begin
                    if (seq_clk_cnt > 0) seq_clk_cnt--;
                    if (seq_clk_cnt == 0) begin
                        seq_clk_cnt = 9'(2 + model_cfg.sample_delay);
                        if (seq_first) begin
                            seq_clk_cnt = seq_clk_cnt + 9'(INIT_DELAY);
                            seq_first   = 1'b0;
                        end
                        seq_pre_cnt = '0;
                        seq_phase   = PH_WAITING;
                    end
                end else if (seq_phase == PH_WAITING || seq_phase == PH_CONVERTING) begin
                    seq_pre_cnt++;
                    if (int'(seq_pre_cnt) >= p) begin
                        seq_pre_cnt = '0;
                        if (seq_clk_cnt > 0) seq_clk_cnt--;
                        if (seq_clk_cnt == 0) begin
                            if (seq_phase == PH_WAITING) begin
                                // Latch the code and add it to the running sum
                                code = cmd.sample_code;
                                if (model_cfg.eight_bit) code = code >> 2;
                                if (seq_samples == 0) seq_sum = 16'(code);
                                else seq_sum = seq_sum + 16'(code);
                                seq_clk_cnt = 9'(11 + model_cfg.sample_length);
                                seq_phase   = PH_CONVERTING;
                                sampled     = 1'b1;
                            end else begin
                                seq_samples++;
                                if (int'(seq_samples) < samples_per_result()) begin
                                    seq_clk_cnt = 9'(2 + model_cfg.sample_delay);
                                    seq_phase   = PH_WAITING;
                                end else begin
                                    // Finish the result and run the window compare
                                    seq_phase = PH_IDLE;
                                    seq_ready = 1'b1;
                                    case (model_cfg.window_mode)
                                        WIN_BELOW:   hit = seq_sum < model_cfg.window_low;
                                        WIN_ABOVE:   hit = seq_sum > model_cfg.window_high;
                                        WIN_INSIDE:  hit = seq_sum > model_cfg.window_low &&
                                                           seq_sum < model_cfg.window_high;
                                        WIN_OUTSIDE: hit = seq_sum < model_cfg.window_low ||
                                                           seq_sum > model_cfg.window_high;
                                        default:     hit = 1'b0;
                                    endcase
                                    if (hit) seq_window = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            OP_ENABLE: begin
                seq_first = 1'b1;
                if (seq_phase == PH_DISABLED) seq_phase = PH_IDLE;
            end
            OP_DISABLE: begin
                seq_first   = 1'b1;
                seq_phase   = PH_DISABLED;
                seq_pre_cnt = '0;
                seq_clk_cnt = '0;
                seq_samples = '0;
            end
            OP_START: begin
                if (seq_phase == PH_IDLE) begin
                    seq_phase   = PH_STARTING;
                    seq_samples = '0;
                    seq_pre_cnt = '0;
                    seq_clk_cnt = 9'(p / 2 + 2);
                end
            end
            OP_CLEAR: begin
                if (cmd.clear_ready) seq_ready = 1'b0;
                if (cmd.clear_window) seq_window = 1'b0;
            end
            default: ;
        endcase
        st.busy_res     = (seq_phase > PH_IDLE);
        st.result       = seq_sum;
        st.result_ready = seq_ready;
        st.window_hit   = seq_window;
        st.sample_now   = sampled;
        return st;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
        if (exp_val !== got_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_val, got_val);
            error_count++;
        end
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Driver: feed one command per beat, hold it while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid <= 1'b0;
            send_gap  = 0;
            send_calm = 0;
        end else begin
            if (in_bus.valid && in_bus.ready) begin
                sent_cmd.operation    = in_bus.operation;
                sent_cmd.clear_ready  = in_bus.clear_ready;
                sent_cmd.clear_window = in_bus.clear_window;
                sent_cmd.sample_code  = in_bus.sample_code;
                expected_status.push_back(predict_status(sent_cmd));
            end
            if (!in_bus.valid || in_bus.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_bus.valid <= 1'b0;
                end else if (cmd_queue.size() > 0) begin
                    next_cmd = cmd_queue.pop_front();
                    in_bus.valid        <= 1'b1;
                    in_bus.operation    <= next_cmd.operation;
                    in_bus.clear_ready  <= next_cmd.clear_ready;
                    in_bus.clear_window <= next_cmd.clear_window;
                    in_bus.sample_code  <= next_cmd.sample_code;
                    if (send_calm > 0) begin
                        send_calm--;
                    end else begin
                        send_gap = draw_gap();
                        if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 200);
                    end
                end else begin
                    in_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each status beat with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            recv_hold = 0;
            recv_calm = 0;
        end else begin
            if (out_bus.valid && out_bus.ready) begin
                if (expected_status.size() == 0) begin
                    $error("status beat with no prediction pending");
                    error_count++;
                end else begin
                    want = expected_status.pop_front();
                    check_field("busy_res", want.busy_res, out_bus.busy_res);
                    check_field("result", want.result, out_bus.result);
                    check_field("result_ready", want.result_ready, out_bus.result_ready);
                    check_field("window_hit", want.window_hit, out_bus.window_hit);
                    check_field("sample_now", want.sample_now, out_bus.sample_now);
                end
                if (recv_calm > 0) begin
                    recv_calm--;
                end else begin
                    recv_hold = draw_gap();
                    if ($urandom_range(0, 49) == 0) recv_calm = $urandom_range(20, 200);
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                out_bus.ready <= 1'b0;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
            (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Write one register, mirror it, and read it back
    task automatic apb_write(t_reg idx, logic [31:0] val);
        logic [31:0] stored;
        case (idx)
            REG_PRESCALE: begin
                model_cfg.prescale_factor = val[8:0];
                stored = 32'(val[8:0]);
            end
            REG_SAMPLE_DELAY: begin
                model_cfg.sample_delay = val[3:0];
                stored = 32'(val[3:0]);
            end
            REG_SAMPLE_LENGTH: begin
                model_cfg.sample_length = val[4:0];
                stored = 32'(val[4:0]);
            end
            REG_ACCUM_LOG2: begin
                model_cfg.accum_log2 = val[2:0];
                stored = 32'(val[2:0]);
            end
            REG_EIGHT_BIT: begin
                model_cfg.eight_bit = val[0];
                stored = 32'(val[0]);
            end
            REG_WINDOW_MODE: begin
                model_cfg.window_mode = val[2:0];
                stored = 32'(val[2:0]);
            end
            REG_WINDOW_LOW: begin
                model_cfg.window_low = val[15:0];
                stored = 32'(val[15:0]);
            end
            default: begin
                model_cfg.window_high = val[15:0];
                stored = 32'(val[15:0]);
            end
        endcase
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        check_field("prdata", stored, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(t_cfg c);
        apb_write(REG_PRESCALE, 32'(c.prescale_factor));
        apb_write(REG_SAMPLE_DELAY, 32'(c.sample_delay));
        apb_write(REG_SAMPLE_LENGTH, 32'(c.sample_length));
        apb_write(REG_ACCUM_LOG2, 32'(c.accum_log2));
        apb_write(REG_EIGHT_BIT, 32'(c.eight_bit));
        apb_write(REG_WINDOW_MODE, 32'(c.window_mode));
        apb_write(REG_WINDOW_LOW, 32'(c.window_low));
        apb_write(REG_WINDOW_HIGH, 32'(c.window_high));
    endtask

    task automatic push_item(logic [2:0] op, logic cr, logic cw, logic [9:0] code);
        t_seq_cmd cmd;
        cmd.operation    = op;
        cmd.clear_ready  = cr;
        cmd.clear_window = cw;
        cmd.sample_code  = code;
        cmd_queue.push_back(cmd);
        items_queued++;
    endtask

    // Random fields, with codes that land on the window edges now and then
    task automatic push_op(logic [2:0] op);
        logic [9:0] code;
        case ($urandom_range(0, 15))
            0:       code = 10'd0;
            1:       code = 10'd1023;
            2:       code = 10'(model_cfg.window_low << (model_cfg.eight_bit ? 2 : 0));
            3:       code = 10'(model_cfg.window_high << (model_cfg.eight_bit ? 2 : 0));
            default: code = 10'($urandom_range(0, 1023));
        endcase
        push_item(op, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), code);
    endtask

    // Ticks with an occasional harmless command mixed in
    task automatic queue_ticks(int count);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 29) == 0) begin
                case ($urandom_range(0, 2))
                    0:       push_op(OP_CLEAR);
                    1:       push_op(OP_START);
                    default: push_op(3'($urandom_range(5, 7)));
                endcase
            end
            push_op(OP_TICK);
        end
    endtask

    // Ticks from a start command until the result is finished
    function automatic int conversion_ticks(bit with_init);
        int p;
        p = prescale_ticks();
        return p / 2 + 2 + (with_init ? INIT_DELAY * p : 0) +
               samples_per_result() * (13 + model_cfg.sample_delay + model_cfg.sample_length) * p;
    endfunction

    task automatic queue_full_run();
        push_op(OP_ENABLE);
        push_op(OP_START);
        queue_ticks(conversion_ticks(1'b1) + $urandom_range(0, 12));
        push_op(OP_CLEAR);
    endtask

    // Mostly complete conversions, some noise and aborted runs
    task automatic queue_phase(int min_items);
        int start_count;
        int r;
        start_count = items_queued;
        while (items_queued - start_count < min_items) begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
                push_op(3'($urandom_range(0, 7)));
            end else if (r == 1) begin
                push_op(OP_ENABLE);
                push_op(OP_START);
                queue_ticks($urandom_range(0, 60));
                push_op(OP_DISABLE);
            end else begin
                queue_full_run();
                if ($urandom_range(0, 1)) begin
                    push_op(OP_START);
                    queue_ticks(conversion_ticks(1'b0) + $urandom_range(0, 12));
                    push_op(OP_CLEAR);
                end
            end
        end
        push_op(OP_DISABLE);
    endtask

    function automatic t_cfg random_config();
        t_cfg c;
        int   r;
        int   top;
        r = $urandom_range(0, 99);
        if (r < 10) c.prescale_factor = 9'($urandom_range(0, 1));
        else if (r < 80) c.prescale_factor = 9'($urandom_range(2, 4));
        else c.prescale_factor = 9'($urandom_range(5, 12));
        c.accum_log2    = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, 2))
                                                       : 3'($urandom_range(3, 7));
        c.sample_delay  = ($urandom_range(0, 99) < 70) ? 4'($urandom_range(0, 3))
                                                       : 4'($urandom_range(0, 15));
        c.sample_length = ($urandom_range(0, 99) < 70) ? 5'($urandom_range(0, 4))
                                                       : 5'($urandom_range(0, 31));
        // Keep long accumulations and slow clocks short
        if (c.accum_log2 >= 3 || c.prescale_factor > 4) begin
            if (c.accum_log2 >= 3) c.prescale_factor = 9'($urandom_range(0, 2));
            c.sample_delay  = 4'($urandom_range(0, 1));
            c.sample_length = 5'($urandom_range(0, 1));
        end
        c.eight_bit   = 1'($urandom_range(0, 1));
        c.window_mode = 3'($urandom_range(0, 7));
        top = (1 << ((c.accum_log2 > MAX_ACCUM_LOG2) ? MAX_ACCUM_LOG2 : c.accum_log2)) *
              (c.eight_bit ? 255 : 1023);
        r = $urandom_range(0, 99);
        if (r < 10) begin
            c.window_low  = 16'd0;
            c.window_high = 16'hFFFF;
        end else begin
            c.window_low  = 16'($urandom_range(0, top));
            c.window_high = 16'($urandom_range(0, top));
            if (r < 85 && c.window_high < c.window_low) begin
                c.window_high = c.window_low + 16'($urandom_range(0, 255));
            end
        end
        return c;
    endfunction

    // Hold until every command is driven and every status beat has come back;
    // sample between edges so the driver and monitor have settled
    task automatic wait_quiet();
        while (cmd_queue.size() > 0 || in_bus.valid || expected_status.size() > 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Stimulus and verdict
    initial begin
        t_cfg cfg;
        int   random_start;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_bus.valid        = 1'b0;
        in_bus.operation    = OP_TICK;
        in_bus.clear_ready  = 1'b0;
        in_bus.clear_window = 1'b0;
        in_bus.sample_code  = '0;
        out_bus.ready       = 1'b0;
        error_count         = 0;
        items_queued        = 0;
        quiet_cycles        = 0;
        model_cfg           = '0;
        model_cfg.prescale_factor = 9'd2;
        seq_phase   = PH_DISABLED;
        seq_pre_cnt = '0;
        seq_clk_cnt = '0;
        seq_samples = '0;
        seq_sum     = '0;
        seq_first   = 1'b0;
        seq_ready   = 1'b0;
        seq_window  = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: ignored commands, repeated enables, start while busy, aborts
        push_item(OP_TICK, 1'b1, 1'b1, 10'd1023);
        push_item(OP_START, 1'b0, 1'b0, 10'd0);
        push_item(3'd5, 1'b1, 1'b0, 10'd1023);
        push_item(3'd6, 1'b0, 1'b1, 10'd0);
        push_item(3'd7, 1'b1, 1'b1, 10'd512);
        push_item(OP_CLEAR, 1'b0, 1'b0, 10'd0);
        push_item(OP_CLEAR, 1'b1, 1'b1, 10'd1023);
        push_item(OP_ENABLE, 1'b0, 1'b0, 10'd0);
        push_item(OP_TICK, 1'b0, 1'b0, 10'd1023);
        push_item(OP_ENABLE, 1'b1, 1'b1, 10'd1023);
        push_item(OP_START, 1'b0, 1'b0, 10'd0);
        push_item(OP_START, 1'b1, 1'b1, 10'd1023);
        push_item(OP_TICK, 1'b0, 1'b1, 10'd0);
        push_item(OP_TICK, 1'b1, 1'b0, 10'd1023);
        push_item(OP_TICK, 1'b0, 1'b0, 10'd0);
        push_item(OP_ENABLE, 1'b0, 1'b0, 10'd0);
        push_item(OP_TICK, 1'b0, 1'b0, 10'd1023);
        push_item(OP_DISABLE, 1'b0, 1'b0, 10'd0);
        push_item(OP_TICK, 1'b0, 1'b0, 10'd1023);
        push_item(OP_START, 1'b0, 1'b0, 10'd0);
        push_item(OP_ENABLE, 1'b0, 1'b0, 10'd0);
        push_item(OP_START, 1'b0, 1'b0, 10'd1023);
        push_item(OP_TICK, 1'b0, 1'b0, 10'd0);
        push_item(OP_DISABLE, 1'b0, 1'b0, 10'd0);
        wait_quiet();

        // Random settings, mostly small sizes
        random_start = items_queued;
        while (items_queued - random_start < RANDOM_ITEMS) begin
            configure(random_config());
            queue_phase(150);
            wait_quiet();
        end

        // Slowest clock: run through the long start delay, then abort
        cfg = '0;
        cfg.prescale_factor = 9'd256;
        cfg.eight_bit       = 1'b1;
        cfg.window_mode     = WIN_ABOVE;
        cfg.window_high     = 16'd100;
        configure(cfg);
        push_op(OP_ENABLE);
        push_op(OP_START);
        queue_ticks(300);
        push_op(OP_DISABLE);
        wait_quiet();

        // Prescale above range acts as the slowest clock
        cfg = '0;
        cfg.prescale_factor = 9'd400;
        cfg.window_mode     = WIN_INSIDE;
        cfg.window_high     = 16'hFFFF;
        configure(cfg);
        push_op(OP_ENABLE);
        push_op(OP_START);
        queue_ticks(300);
        push_op(OP_DISABLE);
        wait_quiet();

        // Longest delays
        cfg = '0;
        cfg.prescale_factor = 9'd2;
        cfg.sample_delay    = 4'd15;
        cfg.sample_length   = 5'd31;
        cfg.window_mode     = WIN_OUTSIDE;
        cfg.window_low      = 16'd30000;
        cfg.window_high     = 16'd35000;
        configure(cfg);
        queue_full_run();
        push_op(OP_DISABLE);
        wait_quiet();

        // Prescale below range, unknown window mode
        cfg = '0;
        cfg.prescale_factor = 9'd0;
        cfg.eight_bit       = 1'b1;
        cfg.window_mode     = 3'd7;
        cfg.window_low      = 16'hFFFF;
        cfg.window_high     = 16'hFFFF;
        configure(cfg);
        queue_full_run();
        push_op(OP_DISABLE);
        wait_quiet();

        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
